[hdl/swdw_pkg.sv]
`timescale 1ns / 1ps

package swdw_pkg;

    localparam int unsigned HDR_W     = 8;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned ACK_W     = 3;
    localparam int unsigned TURN_W    = 3;
    localparam int unsigned CNT_W     = 8;
    localparam int unsigned BITCNT_W  = 6;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_TURNAROUND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE       = 2'd1;

    localparam logic [BITCNT_W-1:0] HDR_BITS  = 6'd8;
    localparam logic [BITCNT_W-1:0] ACK_BITS  = 6'd3;
    localparam logic [BITCNT_W-1:0] DATA_BITS = 6'd32;
    localparam logic [CNT_W-1:0]    ERR_EXTRA = 8'd33;

    localparam logic [ACK_W-1:0] ACK_OK    = 3'd1;
    localparam logic [ACK_W-1:0] ACK_WAIT  = 3'd2;
    localparam logic [ACK_W-1:0] ACK_FAULT = 3'd4;

    typedef enum logic [10:0] {
        PH_IDLE     = 11'b000_0000_0001,
        PH_HDR      = 11'b000_0000_0010,
        PH_TA_REL   = 11'b000_0000_0100,
        PH_ACK      = 11'b000_0000_1000,
        PH_TA_DRV   = 11'b000_0001_0000,
        PH_DATA     = 11'b000_0010_0000,
        PH_PAR      = 11'b000_0100_0000,
        PH_IDLE_LOW = 11'b000_1000_0000,
        PH_TA_WF    = 11'b001_0000_0000,
        PH_ERR      = 11'b010_0000_0000,
        PH_END      = 11'b100_0000_0000
    } swdw_phase_t;

    typedef struct packed {
        logic              start_req;
        logic [HDR_W-1:0]  header;
        logic [WORD_W-1:0] write_data;
        logic              line_in;
    } swdw_item_t;

    typedef struct packed {
        logic             clock_pulse;
        logic             line_out;
        logic             line_drive;
        logic             busy_res;
        logic             done_res;
        logic [ACK_W-1:0] ack_code;
    } swdw_result_t;

    typedef struct packed {
        logic [TURN_W-1:0] turnaround_cycles;
        logic [CNT_W-1:0]  idle_len;
    } swdw_cfg_t;

endpackage

[hdl/swdw_ifs.sv]
`timescale 1ns / 1ps

interface swdw_item_if;
    import swdw_pkg::*;
    logic              valid;
    logic              ready;
    logic              start_req;
    logic [HDR_W-1:0]  header;
    logic [WORD_W-1:0] write_data;
    logic              line_in;
    modport source (output valid, output start_req, output header, output write_data,
                    output line_in, input ready);
    modport sink (input valid, input start_req, input header, input write_data,
                  input line_in, output ready);
endinterface

interface swdw_result_if;
    import swdw_pkg::*;
    logic             valid;
    logic             ready;
    logic             clock_pulse;
    logic             line_out;
    logic             line_drive;
    logic             busy_res;
    logic             done_res;
    logic [ACK_W-1:0] ack_code;
    modport source (output valid, output clock_pulse, output line_out, output line_drive,
                    output busy_res, output done_res, output ack_code, input ready);
    modport sink (input valid, input clock_pulse, input line_out, input line_drive,
                  input busy_res, input done_res, input ack_code, output ready);
endinterface

interface swdw_cfg_if;
    import swdw_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/swd_write_transfer_engine.sv]
`timescale 1ns / 1ps
// Channel  Dir  Beat
// item     in   one SWCLK period: start_req, header, write_data, line_in
// result   out  one per item: clock_pulse, line_out, line_drive, busy_res, done_res, ack_code
// cfg      in   register write: index 0 turnaround_cycles, 1 idle length
//
// One item per clock while item.ready is high; its result sits in the output register on the next cycle.
// Sequencer state and the output register advance together on each accepted beat.
// item.ready drops only while the output register holds a beat the sink has not taken.
// rst_n is asynchronous; after reset the engine is idle, turnaround 1, idle 0.

module swd_write_transfer_engine
    import swdw_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    swdw_item_if.sink     item,
    swdw_result_if.source result,
    swdw_cfg_if.sink      cfg
);

    swdw_cfg_t    cfg_regs;
    swdw_item_t   item_beat;
    swdw_result_t seq_result;
    logic         slot_free;
    logic         accept;

    assign item.ready = slot_free;
    assign accept     = item.valid && slot_free;

    assign item_beat.start_req  = item.start_req;
    assign item_beat.header     = item.header;
    assign item_beat.write_data = item.write_data;
    assign item_beat.line_in    = item.line_in;

    swdw_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_regs (cfg_regs)
    );

    swdw_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item_beat),
        .cfg_regs (cfg_regs),
        .result   (seq_result)
    );

    swdw_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .result    (seq_result),
        .slot_free (slot_free),
        .rsp       (result)
    );

endmodule

[hdl/swdw_cfg.sv]
`timescale 1ns / 1ps

module swdw_cfg
    import swdw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    swdw_cfg_if.sink  cfg,
    output swdw_cfg_t cfg_regs
);

    logic [TURN_W-1:0] turn_reg;
    logic [CNT_W-1:0]  idle_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_reg <= TURN_W'(1);
            idle_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_TURNAROUND: turn_reg <= cfg.data[TURN_W-1:0];
                CFG_IDLE:       idle_reg <= cfg.data[CNT_W-1:0];
                default:        ;
            endcase
        end
    end

    assign cfg_regs.turnaround_cycles = turn_reg;
    assign cfg_regs.idle_len          = idle_reg;

endmodule

[hdl/swdw_seq.sv]
`timescale 1ns / 1ps

module swdw_seq
    import swdw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  swdw_item_t   item,
    input  swdw_cfg_t    cfg_regs,
    output swdw_result_t result
);

    swdw_phase_t         phase_reg, phase_next;
    logic [BITCNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [WORD_W-1:0]   shift_reg, shift_next;
    logic [HDR_W-1:0]    hdr_reg, hdr_next;
    logic [ACK_W-1:0]    ack_reg, ack_next;
    logic                par_reg, par_next;
    logic [CNT_W-1:0]    cyc_reg, cyc_next;

    logic [CNT_W-1:0]    eff_turn;
    logic [CNT_W-1:0]    cyc_dec;
    logic [BITCNT_W-1:0] bit_inc;

    assign eff_turn = (cfg_regs.turnaround_cycles == '0) ? CNT_W'(1)
                                                        : CNT_W'(cfg_regs.turnaround_cycles);
    assign cyc_dec  = cyc_reg - CNT_W'(1);
    assign bit_inc  = bit_cnt_reg + BITCNT_W'(1);

    always_comb
    begin
        phase_next   = phase_reg;
        bit_cnt_next = bit_cnt_reg;
        shift_next   = shift_reg;
        hdr_next     = hdr_reg;
        ack_next     = ack_reg;
        par_next     = par_reg;
        cyc_next     = cyc_reg;

        result.clock_pulse = 1'b0;
        result.line_out    = 1'b1;
        result.line_drive  = 1'b1;
        result.busy_res    = 1'b0;
        result.done_res    = 1'b0;
        result.ack_code    = '0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (item.start_req)
                begin
                    shift_next         = item.write_data;
                    par_next           = ^item.write_data;
                    ack_next           = '0;
                    result.clock_pulse = 1'b1;
                    result.busy_res    = 1'b1;
                    result.line_out    = item.header[0];
                    hdr_next           = item.header >> 1;
                    bit_cnt_next       = BITCNT_W'(1);
                    phase_next         = PH_HDR;
                end
            end
            PH_HDR:
            begin
                result.clock_pulse = 1'b1;
                result.busy_res    = 1'b1;
                result.line_out    = hdr_reg[0];
                hdr_next           = hdr_reg >> 1;
                bit_cnt_next       = bit_inc;
                if (bit_inc >= HDR_BITS)
                begin
                    phase_next = PH_TA_REL;
                    cyc_next   = eff_turn;
                end
            end
            PH_TA_REL:
            begin
                result.clock_pulse = 1'b1;
                result.busy_res    = 1'b1;
                result.line_drive  = 1'b0;
                result.line_out    = 1'b0;
                cyc_next           = cyc_dec;
                if (cyc_dec == '0)
                begin
                    phase_next   = PH_ACK;
                    bit_cnt_next = '0;
                end
            end
            PH_ACK:
            begin
                result.clock_pulse = 1'b1;
                result.busy_res    = 1'b1;
                result.line_drive  = 1'b0;
                result.line_out    = 1'b0;
                case (bit_cnt_reg[1:0])
                    2'd0:    ack_next = ack_reg | {2'b00, item.line_in};
                    2'd1:    ack_next = ack_reg | {1'b0, item.line_in, 1'b0};
                    2'd2:    ack_next = ack_reg | {item.line_in, 2'b00};
                    default: ack_next = ack_reg;
                endcase
                bit_cnt_next = bit_inc;
                if (bit_inc >= ACK_BITS)
                begin
                    if (ack_next == ACK_OK)
                    begin
                        phase_next = PH_TA_DRV;
                        cyc_next   = eff_turn;
                    end
                    else if (ack_next == ACK_WAIT || ack_next == ACK_FAULT)
                    begin
                        phase_next = PH_TA_WF;
                        cyc_next   = eff_turn;
                    end
                    else
                    begin
                        phase_next = PH_ERR;
                        cyc_next   = eff_turn + ERR_EXTRA;
                    end
                end
            end
            PH_TA_DRV:
            begin
                result.clock_pulse = 1'b1;
                result.busy_res    = 1'b1;
                cyc_next           = cyc_dec;
                if (cyc_dec == '0)
                begin
                    phase_next   = PH_DATA;
                    bit_cnt_next = '0;
                end
            end
            PH_DATA:
            begin
                result.clock_pulse = 1'b1;
                result.busy_res    = 1'b1;
                result.line_out    = shift_reg[0];
                shift_next         = shift_reg >> 1;
                bit_cnt_next       = bit_inc;
                if (bit_inc >= DATA_BITS)
                    phase_next = PH_PAR;
            end
            PH_PAR:
            begin
                result.clock_pulse = 1'b1;
                result.busy_res    = 1'b1;
                result.line_out    = par_reg;
                if (cfg_regs.idle_len == '0)
                    phase_next = PH_END;
                else
                begin
                    phase_next = PH_IDLE_LOW;
                    cyc_next   = cfg_regs.idle_len;
                end
            end
            PH_IDLE_LOW:
            begin
                result.clock_pulse = 1'b1;
                result.busy_res    = 1'b1;
                result.line_out    = 1'b0;
                cyc_next           = cyc_dec;
                if (cyc_dec == '0)
                    phase_next = PH_END;
            end
            PH_TA_WF, PH_ERR:
            begin
                result.clock_pulse = 1'b1;
                result.busy_res    = 1'b1;
                result.line_drive  = 1'b0;
                result.line_out    = 1'b0;
                cyc_next           = cyc_dec;
                if (cyc_dec == '0)
                    phase_next = PH_END;
            end
            PH_END:
            begin
                result.done_res = 1'b1;
                result.ack_code = ack_reg;
                phase_next      = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            bit_cnt_reg <= '0;
            shift_reg   <= '0;
            hdr_reg     <= '0;
            ack_reg     <= '0;
            par_reg     <= 1'b0;
            cyc_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            bit_cnt_reg <= bit_cnt_next;
            shift_reg   <= shift_next;
            hdr_reg     <= hdr_next;
            ack_reg     <= ack_next;
            par_reg     <= par_next;
            cyc_reg     <= cyc_next;
        end
    end

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result.done_res |-> !result.busy_res && !result.clock_pulse)
        else $error("closing beat reported busy or clocked");

    a_release_low: assert property (@(posedge clk) disable iff (!rst_n)
        !result.line_drive |-> !result.line_out && result.busy_res)
        else $error("released line not low or outside a transfer");

    a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_END |=> phase_reg == PH_IDLE)
        else $error("closing beat did not return to idle");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_IDLE && item.start_req |=> phase_reg == PH_HDR)
        else $error("start not taken while idle");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(phase_reg) && $stable(cyc_reg) && $stable(bit_cnt_reg))
        else $error("state moved without a beat");

endmodule

[hdl/swdw_out_reg.sv]
`timescale 1ns / 1ps

module swdw_out_reg
    import swdw_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  swdw_result_t  result,
    output logic          slot_free,
    swdw_result_if.source rsp
);

    logic         valid_reg;
    swdw_result_t data_reg;

    assign slot_free = !valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (slot_free)
            valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

    assign rsp.valid       = valid_reg;
    assign rsp.clock_pulse = data_reg.clock_pulse;
    assign rsp.line_out    = data_reg.line_out;
    assign rsp.line_drive  = data_reg.line_drive;
    assign rsp.busy_res    = data_reg.busy_res;
    assign rsp.done_res    = data_reg.done_res;
    assign rsp.ack_code    = data_reg.ack_code;

endmodule
